@@ rtl/jls_pkg.sv @@
// Shared types, codes and helpers of the Jacobi linear solver.
`timescale 1ns / 1ps
`default_nettype none

package jls_pkg;

	localparam int DATA_W    = 32;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 5;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_USED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS = 2'd2;

	// solve status codes
	localparam logic [1:0] ST_CONVERGED = 2'd0;
	localparam logic [1:0] ST_ZERO_DIAG = 2'd1;
	localparam logic [1:0] ST_SWEEP_CAP = 2'd2;

	typedef struct packed {
		logic       load_wr;
		logic       solve_init;
		logic       chk_zero;
		logic       den_ld;
		logic       div_start;
		logic       sc_wr;
		logic       mac_issue;
		logic       mac_init;
		logic       mac_last;
		logic       sweep_start;
		logic       copy_prev;
		logic       zero_cur;
		logic       emit_ld;
		logic       emit_final;
		logic [1:0] emit_status;
	} jls_cmd_t;

	typedef struct packed {
		logic zero_diag;
		logic div_done;
		logic row_done;
		logic not_done;
		logic out_free;
	} jls_stat_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/jls_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module jls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 272
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/jls_div.sv @@
// Radix-2 restoring divider: saturated (num * 2^FRAC_BITS) / den, truncated toward zero.
`timescale 1ns / 1ps
`default_nettype none

module jls_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire signed [31:0]   num,
	input  wire signed [31:0]   den,
	output logic                done,
	output logic signed [31:0]  quot
);

	localparam int NUMW = 32 + FRAC_BITS;
	localparam int CW   = $clog2(NUMW + 1);

	logic            busy_q;
	logic            fin_q;
	logic [CW-1:0]   cnt_q;
	logic [NUMW-1:0] nsh_q;
	logic [NUMW-1:0] quo_q;
	logic [31:0]     rem_q;
	logic [31:0]     dmag_q;
	logic            neg_q;

	logic [31:0] nmag;
	logic [31:0] dmag;
	logic [32:0] trial;
	logic        fits;

	assign nmag  = num[31] ? 32'(-num) : 32'(num);
	assign dmag  = den[31] ? 32'(-den) : 32'(den);
	assign trial = {rem_q, nsh_q[NUMW-1]};
	assign fits  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nsh_q  <= {nmag, {FRAC_BITS{1'b0}}};
			quo_q  <= '0;
			rem_q  <= '0;
			dmag_q <= dmag;
			neg_q  <= num[31] ^ den[31];
		end else if (busy_q) begin
			nsh_q <= {nsh_q[NUMW-2:0], 1'b0};
			quo_q <= {quo_q[NUMW-2:0], fits};
			rem_q <= fits ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (|quo_q[NUMW-1:31]) ? 32'sh80000000 : 32'(-quo_q[31:0]);
		end else begin
			quot = (|quo_q[NUMW-1:31]) ? 32'sh7FFFFFFF : 32'(quo_q[31:0]);
		end
	end

	assign done = fin_q;

endmodule

`default_nettype wire

@@ rtl/jls_datapath.sv @@
// Solver datapath: system and scaled stores, divider, MAC pipeline, estimates, output word.
`timescale 1ns / 1ps
`default_nettype none

module jls_datapath #(
	parameter int MAX_DIM   = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  jls_pkg::jls_cmd_t                cmd,
	output jls_pkg::jls_stat_t               stat,
	input  wire [$clog2(MAX_DIM)-1:0]        row_sel,
	input  wire [$clog2(MAX_DIM+1)-1:0]      col_sel,
	input  wire [$clog2(MAX_DIM+1)-1:0]      dim_n,
	input  wire [30:0]                       tolerance,
	input  wire [jls_pkg::ROW_W-1:0]         in_row,
	input  wire [jls_pkg::COL_W-1:0]         in_col,
	input  wire signed [jls_pkg::DATA_W-1:0] in_coef,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [jls_pkg::ROW_W-1:0]        out_index,
	output logic signed [jls_pkg::DATA_W-1:0] out_value,
	output logic [1:0]                       out_status,
	output logic                             out_final
);

	import jls_pkg::*;

	localparam int IW      = $clog2(MAX_DIM);
	localparam int ROW_LEN = MAX_DIM + 1;
	localparam int DEPTH   = MAX_DIM * ROW_LEN;
	localparam int AW      = $clog2(DEPTH);
	localparam longint GUESS_L = 64'sd1000 * (64'sd1 <<< FRAC_BITS);
	localparam logic signed [DATA_W-1:0] GUESS =
		(GUESS_L > 64'sd2147483647) ? 32'sh7FFFFFFF : 32'(GUESS_L);

	// store addressing
	logic [AW-1:0] sv_addr;
	logic [AW-1:0] ld_addr;
	logic          ld_in_range;

	assign sv_addr = AW'(int'(row_sel) * ROW_LEN + int'(col_sel));
	assign ld_addr = AW'(int'(in_row) * ROW_LEN + int'(in_col));
	assign ld_in_range = (int'(in_row) < int'(dim_n)) && (int'(in_col) <= int'(dim_n));

	logic signed [DATA_W-1:0] st_rd;
	logic signed [DATA_W-1:0] sc_rd;
	logic signed [DATA_W-1:0] sc_val;

	jls_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (cmd.load_wr && ld_in_range),
		.waddr (ld_addr),
		.wdata (in_coef),
		.raddr (sv_addr),
		.rdata (st_rd)
	);

	jls_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_scaled (
		.clk   (clk),
		.we    (cmd.sc_wr),
		.waddr (sv_addr),
		.wdata (sc_val),
		.raddr (sv_addr),
		.rdata (sc_rd)
	);

	// scaling: b_i/a_ii kept, -a_ij/a_ii for the rest, zero on the diagonal
	logic signed [DATA_W-1:0] den_q;
	logic signed [DATA_W-1:0] div_quot;
	logic                     div_done;

	jls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (st_rd),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		if (col_sel == dim_n) begin
			sc_val = div_quot;
		end else if (int'(col_sel) == int'(row_sel)) begin
			sc_val = '0;
		end else if (div_quot == 32'sh80000000) begin
			sc_val = 32'sh7FFFFFFF;
		end else begin
			sc_val = -div_quot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.den_ld) begin
			den_q <= st_rd;
		end
	end

	logic zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b0;
		end else if (cmd.solve_init) begin
			zero_q <= 1'b0;
		end else if (cmd.chk_zero && st_rd == '0) begin
			zero_q <= 1'b1;
		end
	end

	// estimates
	logic signed [DATA_W-1:0] prev_q [MAX_DIM];
	logic signed [DATA_W-1:0] cur_q  [MAX_DIM];
	logic [IW-1:0]            pidx;
	logic signed [DATA_W-1:0] cur_sel;

	assign pidx    = col_sel[IW-1:0];
	assign cur_sel = cur_q[row_sel];

	// MAC pipeline
	logic                     v_s1, init_s1, last_s1, diag_s1;
	logic signed [DATA_W-1:0] prev_s1;
	logic                     v_s2, init_s2, last_s2;
	logic signed [63:0]       prod_s2;
	logic signed [DATA_W-1:0] b_s2;
	logic signed [DATA_W-1:0] pdiag_q;
	logic signed [63:0]       acc_q;
	logic signed [63:0]       sum;
	logic                     rdone_q;
	logic                     notdone_q;

	assign sum = acc_q + (prod_s2 >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			rdone_q <= 1'b0;
		end else begin
			v_s1    <= cmd.mac_issue;
			v_s2    <= v_s1;
			rdone_q <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		init_s1 <= cmd.mac_init;
		last_s1 <= cmd.mac_last;
		diag_s1 <= int'(col_sel) == int'(row_sel);
		prev_s1 <= prev_q[pidx];
		init_s2 <= init_s1;
		last_s2 <= last_s1;
		prod_s2 <= sc_rd * prev_s1;
		b_s2    <= sc_rd;
		if (v_s1 && diag_s1) begin
			pdiag_q <= prev_s1;
		end
		if (v_s2) begin
			acc_q <= init_s2 ? 64'(b_s2) : sum;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_DIM; k++) begin
			if (cmd.solve_init) begin
				prev_q[k] <= GUESS;
			end else if (cmd.copy_prev) begin
				prev_q[k] <= cur_q[k];
			end
		end
		for (int k = 0; k < MAX_DIM; k++) begin
			if (cmd.solve_init) begin
				cur_q[k] <= GUESS;
			end else if (cmd.zero_cur) begin
				cur_q[k] <= '0;
			end
		end
		if (v_s2 && last_s2 && !init_s2) begin
			cur_q[row_sel] <= sat32(sum);
		end
	end

	// convergence test on the row just finished
	logic signed [32:0] diff;
	logic [32:0]        adiff;

	assign diff  = {cur_sel[DATA_W-1], cur_sel} - {pdiag_q[DATA_W-1], pdiag_q};
	assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notdone_q <= 1'b0;
		end else if (cmd.sweep_start) begin
			notdone_q <= 1'b0;
		end else if (rdone_q && adiff >= {2'b00, tolerance}) begin
			notdone_q <= 1'b1;
		end
	end

	// output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_index  <= ROW_W'(row_sel);
			out_value  <= cur_sel;
			out_status <= cmd.emit_status;
			out_final  <= cmd.emit_final;
		end
	end

	assign stat.zero_diag = zero_q;
	assign stat.div_done  = div_done;
	assign stat.row_done  = rdone_q;
	assign stat.not_done  = notdone_q;
	assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

@@ rtl/jls_ctrl.sv @@
// Solver sequencer: load, diagonal check, scaling, sweeps and result emission.
`timescale 1ns / 1ps
`default_nettype none

module jls_ctrl #(
	parameter int MAX_DIM = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_valid,
	input  wire                          s_last,
	output logic                         s_ready,
	input  wire [$clog2(MAX_DIM+1)-1:0]  dim_n,
	input  wire [15:0]                   max_sweeps,
	input  jls_pkg::jls_stat_t           stat,
	output jls_pkg::jls_cmd_t            cmd,
	output logic [$clog2(MAX_DIM)-1:0]   row_sel,
	output logic [$clog2(MAX_DIM+1)-1:0] col_sel
);

	import jls_pkg::*;

	localparam int IW = $clog2(MAX_DIM);
	localparam int NW = $clog2(MAX_DIM + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHK    = 4'd1;
	localparam logic [3:0] S_CHKW   = 4'd2;
	localparam logic [3:0] S_CHKEND = 4'd3;
	localparam logic [3:0] S_DRD    = 4'd4;
	localparam logic [3:0] S_DDEN   = 4'd5;
	localparam logic [3:0] S_DNA    = 4'd6;
	localparam logic [3:0] S_DNUM   = 4'd7;
	localparam logic [3:0] S_DWAIT  = 4'd8;
	localparam logic [3:0] S_SWST   = 4'd9;
	localparam logic [3:0] S_MB     = 4'd10;
	localparam logic [3:0] S_MT     = 4'd11;
	localparam logic [3:0] S_MW     = 4'd12;
	localparam logic [3:0] S_SWEND  = 4'd13;
	localparam logic [3:0] S_EMIT   = 4'd14;

	logic [3:0]    state_q;
	logic [IW-1:0] row_q;
	logic [NW-1:0] col_q;
	logic [15:0]   sweep_q;
	logic [1:0]    status_q;

	logic        last_row;
	logic        last_term;
	logic [15:0] sweep_nxt;
	logic        cap_hit;

	assign last_row  = int'(row_q) == int'(dim_n) - 1;
	assign last_term = int'(col_q) == int'(dim_n) - 1;
	assign sweep_nxt = sweep_q + 16'd1;
	assign cap_hit   = (sweep_nxt == 16'd0) || (sweep_nxt >= max_sweeps);
	assign row_sel   = row_q;
	assign col_sel   = col_q;
	assign s_ready   = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.emit_status = status_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_wr    = s_valid;
				cmd.solve_init = s_valid && s_last;
			end
			S_CHKW:   cmd.chk_zero = 1'b1;
			S_CHKEND: cmd.zero_cur = stat.zero_diag;
			S_DDEN:   cmd.den_ld = 1'b1;
			S_DNUM:   cmd.div_start = 1'b1;
			S_DWAIT:  cmd.sc_wr = stat.div_done;
			S_SWST:   cmd.sweep_start = 1'b1;
			S_MB: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_init  = 1'b1;
			end
			S_MT: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_last  = last_term;
			end
			S_SWEND:  cmd.copy_prev = stat.not_done && !cap_hit;
			S_EMIT: begin
				cmd.emit_ld    = stat.out_free;
				cmd.emit_final = last_row;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			sweep_q  <= '0;
			status_q <= ST_CONVERGED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_valid && s_last) begin
						row_q   <= '0;
						col_q   <= '0;
						sweep_q <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: state_q <= S_CHKW;
				S_CHKW: begin
					if (last_row) begin
						state_q <= S_CHKEND;
					end else begin
						row_q   <= row_q + IW'(1);
						col_q   <= NW'(int'(row_q) + 1);
						state_q <= S_CHK;
					end
				end
				S_CHKEND: begin
					row_q <= '0;
					col_q <= '0;
					if (stat.zero_diag) begin
						status_q <= ST_ZERO_DIAG;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_DRD;
					end
				end
				S_DRD: state_q <= S_DDEN;
				S_DDEN: begin
					col_q   <= '0;
					state_q <= S_DNA;
				end
				S_DNA:  state_q <= S_DNUM;
				S_DNUM: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (stat.div_done) begin
						if (col_q == dim_n) begin
							if (last_row) begin
								row_q   <= '0;
								state_q <= S_SWST;
							end else begin
								row_q   <= row_q + IW'(1);
								col_q   <= NW'(int'(row_q) + 1);
								state_q <= S_DRD;
							end
						end else begin
							col_q   <= col_q + NW'(1);
							state_q <= S_DNA;
						end
					end
				end
				S_SWST: begin
					col_q   <= dim_n;
					state_q <= S_MB;
				end
				S_MB: begin
					col_q   <= '0;
					state_q <= S_MT;
				end
				S_MT: begin
					if (last_term) begin
						state_q <= S_MW;
					end else begin
						col_q <= col_q + NW'(1);
					end
				end
				S_MW: begin
					if (stat.row_done) begin
						if (last_row) begin
							state_q <= S_SWEND;
						end else begin
							row_q   <= row_q + IW'(1);
							col_q   <= dim_n;
							state_q <= S_MB;
						end
					end
				end
				S_SWEND: begin
					sweep_q <= sweep_nxt;
					row_q   <= '0;
					if (!stat.not_done) begin
						status_q <= ST_CONVERGED;
						state_q  <= S_EMIT;
					end else if (cap_hit) begin
						status_q <= ST_SWEEP_CAP;
						state_q  <= S_EMIT;
					end else begin
						state_q <= S_SWST;
					end
				end
				S_EMIT: begin
					if (stat.out_free) begin
						if (last_row) begin
							state_q <= S_IDLE;
						end else begin
							row_q <= row_q + IW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a solve always starts from row zero with the sweep count cleared
	a_solve_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && s_valid && s_last) |=>
		(state_q == S_CHK && row_q == '0 && sweep_q == 16'd0))
		else $error("solve did not start cleanly");

	// the MAC pipeline finishes a row only while the sequencer waits for it
	a_row_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.row_done |-> state_q == S_MW)
		else $error("row finished outside the wait state");

	// divider completions line up with the scaling wait
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> state_q == S_DWAIT)
		else $error("divider finished outside the wait state");

	// the final word of a run returns the block to loading
	a_emit_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && cmd.emit_ld && cmd.emit_final) |=> state_q == S_IDLE)
		else $error("no return to load after the final word");

endmodule

`default_nettype wire

@@ rtl/jacobi_linear_solver.sv @@
// Top level of the Jacobi linear solver: configuration registers, sequencer and datapath.
//
// Load the augmented system [A|b] one word per cycle, each word a Q16.16 coefficient
// addressed by row and column; column equal to dim_used carries the right-hand side.
// Words outside the active system are dropped. The word with tlast set starts the solve,
// and no input is taken until the run's last result word has been loaded into the output
// register. The solve checks every diagonal, then scales each row into b_i/a_ii and
// -a_ij/a_ii with one shared bit-serial divider, and then runs Jacobi sweeps through one
// 32x32 multiplier until every component moves by less than tolerance or max_sweeps
// sweeps have run. n result words follow, one per cycle when the sink is ready; m_tuser
// carries the status (converged, zero diagonal, sweep cap) and tlast marks the last
// component. With a zero diagonal no sweep runs and every result is zero. The system store
// keeps its contents between solves, so a later solve may rewrite only some coefficients.
// Configuration writes are taken at any time but must only be issued while idle.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_linear_solver #(
	parameter int MAX_DIM   = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	// input words
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [47:0] s_tdata,   // row_index[3:0], col_index[8:4], coef_value[40:9]
	input  wire        s_tlast,   // load_done
	// result words
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata,  // unknown_index[3:0], solution_value[35:4]
	output logic [1:0] m_tuser,   // solve_status[1:0]
	output logic       m_tlast,   // final_flag
	// configuration writes
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [jls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0] cfg_data
);

	import jls_pkg::*;

	localparam int IW = $clog2(MAX_DIM);
	localparam int NW = $clog2(MAX_DIM + 1);

	// configuration registers
	logic [4:0]  dim_used_q;
	logic [30:0] tolerance_q;
	logic [15:0] max_sweeps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_used_q   <= 5'd16;
			tolerance_q  <= 31'd66;
			max_sweeps_q <= 16'd1000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DIM_USED:   dim_used_q   <= cfg_data[4:0];
				REG_TOLERANCE:  tolerance_q  <= cfg_data[30:0];
				REG_MAX_SWEEPS: max_sweeps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// active dimension: zero acts as one, anything past MAX_DIM as MAX_DIM
	logic [NW-1:0] dim_n;

	always_comb begin
		if (dim_used_q == 5'd0) begin
			dim_n = NW'(1);
		end else if (int'(dim_used_q) > MAX_DIM) begin
			dim_n = NW'(MAX_DIM);
		end else begin
			dim_n = NW'(dim_used_q);
		end
	end

	jls_cmd_t      cmd;
	jls_stat_t     stat;
	logic [IW-1:0] row_sel;
	logic [NW-1:0] col_sel;

	logic [ROW_W-1:0]         out_index;
	logic signed [DATA_W-1:0] out_value;

	jls_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_valid    (s_tvalid),
		.s_last     (s_tlast),
		.s_ready    (s_tready),
		.dim_n      (dim_n),
		.max_sweeps (max_sweeps_q),
		.stat       (stat),
		.cmd        (cmd),
		.row_sel    (row_sel),
		.col_sel    (col_sel)
	);

	jls_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.row_sel    (row_sel),
		.col_sel    (col_sel),
		.dim_n      (dim_n),
		.tolerance  (tolerance_q),
		.in_row     (s_tdata[3:0]),
		.in_col     (s_tdata[8:4]),
		.in_coef    (s_tdata[40:9]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_index  (out_index),
		.out_value  (out_value),
		.out_status (m_tuser),
		.out_final  (m_tlast)
	);

	assign m_tdata = {4'b0000, out_value, out_index};

endmodule

`default_nettype wire

@@ tb/sv/jls_checker.sv @@
// Checker for the Jacobi solver: watches all channels, predicts result words and compares them.
`timescale 1ns / 1ps

module jls_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	input  wire        s_tready,
	input  wire [47:0] s_tdata,
	input  wire        s_tlast,
	input  wire        m_tvalid,
	input  wire        m_tready,
	input  wire [39:0] m_tdata,
	input  wire [1:0]  m_tuser,
	input  wire        m_tlast,
	input  wire        cfg_valid,
	input  wire        cfg_ready,
	input  wire [jls_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [31:0] cfg_data,
	output int         errors,
	output int         pending
);

	import jls_pkg::*;

	typedef struct packed {
		logic [3:0]         idx;
		logic signed [31:0] val;
		logic [1:0]         status;
		logic               fin;
	} soln_word_t;

	soln_word_t         soln_q[$];
	logic signed [31:0] coef_mem[16][17];
	logic [4:0]         dim_reg;
	logic [30:0]        tol_reg;
	logic [15:0]        cap_reg;

	function automatic int dim_eff();
		if (dim_reg == 5'd0) return 1;
		if (dim_reg > 5'd16) return 16;
		return int'(dim_reg);
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] qdiv(input logic signed [31:0] num,
			input logic signed [31:0] den);
		return clip32((longint'(num) <<< 16) / longint'(den));
	endfunction

	// full Jacobi solve on the stored system, pushes one word per unknown
	function automatic void predict_solution();
		int                 n;
		logic [1:0]         st;
		logic signed [31:0] bsc[16];
		logic signed [31:0] msc[16][16];
		logic signed [31:0] prev[16];
		logic signed [31:0] cur[16];
		logic [15:0]        sweeps;
		longint             acc;
		longint             diff;
		bit                 zero_seen;
		bit                 settled;
		soln_word_t         w;
		n = dim_eff();
		zero_seen = 0;
		for (int i = 0; i < 16; i++) begin
			prev[i] = 32'sd1000 <<< 16;
			cur[i] = prev[i];
		end
		for (int i = 0; i < n; i++)
			if (coef_mem[i][i] == 0) zero_seen = 1;
		if (zero_seen) begin
			for (int i = 0; i < n; i++) cur[i] = 0;
			st = ST_ZERO_DIAG;
		end else begin
			for (int i = 0; i < n; i++) begin
				bsc[i] = qdiv(coef_mem[i][n], coef_mem[i][i]);
				for (int j = 0; j < n; j++)
					msc[i][j] = (i == j) ? 32'sd0 :
						clip32(-longint'(qdiv(coef_mem[i][j], coef_mem[i][i])));
			end
			sweeps = 0;
			forever begin
				for (int i = 0; i < n; i++) begin
					acc = longint'(bsc[i]);
					for (int j = 0; j < n; j++)
						acc += (longint'(msc[i][j]) * longint'(prev[j])) >>> 16;
					cur[i] = clip32(acc);
				end
				sweeps = sweeps + 16'd1;
				settled = 1;
				for (int i = 0; i < n; i++) begin
					diff = longint'(cur[i]) - longint'(prev[i]);
					if (diff < 0) diff = -diff;
					if (diff >= longint'(tol_reg)) settled = 0;
				end
				if (settled) begin
					st = ST_CONVERGED;
					break;
				end
				if (sweeps == 16'd0 || sweeps >= cap_reg) begin
					st = ST_SWEEP_CAP;
					break;
				end
				for (int i = 0; i < n; i++) prev[i] = cur[i];
			end
		end
		for (int i = 0; i < n; i++) begin
			w.idx = i[3:0];
			w.val = cur[i];
			w.status = st;
			w.fin = (i == n - 1);
			soln_q.push_back(w);
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: mismatch on %s, got %0h, want %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		soln_word_t exp_w;
		int         n;
		if (!arst_n) begin
			dim_reg = 5'd16;
			tol_reg = 31'd66;
			cap_reg = 16'd1000;
			soln_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIM_USED:   dim_reg = cfg_data[4:0];
					REG_TOLERANCE:  tol_reg = cfg_data[30:0];
					REG_MAX_SWEEPS: cap_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				n = dim_eff();
				if (int'(s_tdata[3:0]) < n && int'(s_tdata[8:4]) <= n)
					coef_mem[s_tdata[3:0]][s_tdata[8:4]] = s_tdata[40:9];
				if (s_tlast) predict_solution();
			end
			if (m_tvalid && m_tready) begin
				if (soln_q.size() == 0) begin
					report("unexpected word", m_tdata[35:4], 32'h0);
				end else begin
					exp_w = soln_q.pop_front();
					if (m_tdata[3:0] != exp_w.idx)
						report("unknown_index", 32'(m_tdata[3:0]), 32'(exp_w.idx));
					if (m_tdata[35:4] != exp_w.val)
						report("solution_value", m_tdata[35:4], exp_w.val);
					if (m_tuser != exp_w.status)
						report("solve_status", 32'(m_tuser), 32'(exp_w.status));
					if (m_tlast != exp_w.fin)
						report("final_flag", 32'(m_tlast), 32'(exp_w.fin));
				end
			end
			pending = soln_q.size();
		end
	end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top of the Jacobi solver: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import jls_pkg::*;

	localparam int IDLE_LIMIT = 400000;  // cycles with no word moving on any channel
	localparam int DRAIN_GAP  = 40;      // settle time after the last result word
	localparam int HOLD_LEN   = 3000;    // long sink back-pressure stretch

	// kinds of generated systems
	localparam int SYS_DOMINANT = 0;
	localparam int SYS_RANDOM   = 1;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // row_index[3:0], col_index[8:4], coef_value[40:9]
	logic        s_tlast = 1'b0; // load_done
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // unknown_index[3:0], solution_value[35:4]
	logic [1:0]  m_tuser;        // solve_status[1:0]
	logic        m_tlast;        // final_flag
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int errors;
	int pending;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit snk_hold = 0;
	bit hold_req = 0;
	int idle_cycles = 0;
	int words_sent = 0;
	bit written[16][17];

	jacobi_linear_solver dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	jls_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// sink: random ready, forced low during a hold stretch
	always @(negedge clk) begin
		m_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
	end

	// long hold-off, counted here so the sender keeps pushing meanwhile
	always begin
		wait (hold_req);
		snk_hold = 1;
		repeat (HOLD_LEN) @(negedge clk);
		snk_hold = 0;
		hold_req = 0;
	end

	// watchdog: any word moving resets the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
				!arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t ns: watchdog expired", $realtime);
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one input word; called at a falling edge, returns at the falling edge after acceptance.
	// tvalid is left high so back-to-back words need no drop.
	task automatic send_word(input logic [3:0] r, input logic [4:0] c,
			input logic [31:0] v, input bit last);
		bit ok;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, v, c, r};
		s_tlast <= last;
		ok = 0;
		while (!ok) begin
			#1;
			ok = s_tready;
			@(negedge clk);
		end
		words_sent++;
	endtask

	// sender pause until all results are back, plus settle time
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		bit ok;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		ok = 0;
		while (!ok) begin
			#1;
			ok = cfg_ready;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input int dim, input logic [31:0] tol, input logic [31:0] cap);
		write_reg(REG_DIM_USED, dim);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_MAX_SWEEPS, cap);
	endtask

	// dominant diagonal keeps the sweep contracting (off-diagonal row sum below half)
	function automatic logic [31:0] pick_coef(input int n, input int r, input int c,
			input int kind);
		logic [31:0] mag;
		if (kind == SYS_RANDOM) return $urandom;
		if (c == n) return $signed($urandom) >>> 5;
		if (r == c) begin
			mag = ($urandom_range(100, 4) << 16) | $urandom_range(65535);
		end else begin
			mag = $urandom_range(65536 * 2 / n);
		end
		return $urandom_range(1) ? -mag : mag;
	endfunction

	// word the block drops: row past the system or column past the right-hand side
	task automatic send_stray(input int n, input bit last);
		if (n < 16 && $urandom_range(1))
			send_word(4'($urandom_range(15, n)), 5'($urandom_range(31)), $urandom, last);
		else
			send_word(4'($urandom_range(15)), 5'($urandom_range(31, n + 1)), $urandom, last);
	endtask

	// full load of [A|b] with strays mixed in; tlast on the final word
	task automatic load_system(input int n, input int kind);
		bit stray_last;
		stray_last = ($urandom_range(9) == 0);
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c <= n; c++) begin
				if ($urandom_range(99) < 12) send_stray(n, 0);
				send_word(4'(r), 5'(c), pick_coef(n, r, c, kind),
					!stray_last && r == n - 1 && c == n);
				written[r][c] = 1;
			end
		end
		if (stray_last) send_stray(n, 1);
	endtask

	// rewrite a few entries of a system already in the store
	task automatic patch_system(input int n);
		int r;
		int c;
		for (int k = 0; k < 3; k++) begin
			r = $urandom_range(n - 1);
			c = $urandom_range(n);
			send_word(4'(r), 5'(c), pick_coef(n, r, c, SYS_DOMINANT), k == 2);
		end
	endtask

	function automatic bit all_written(input int n);
		for (int r = 0; r < n; r++)
			for (int c = 0; c <= n; c++)
				if (!written[r][c]) return 0;
		return 1;
	endfunction

	task automatic random_phase(input int src_pct, input int snk_pct, input bit squeeze);
		int n;
		int start;
		int pick;
		drain();
		n = $urandom_range(5, 2);
		set_config(n, $urandom_range(4000, 8), $urandom_range(300, 30));
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		start = words_sent;
		if (squeeze) hold_req = 1;
		while (words_sent - start < 15) begin
			pick = $urandom_range(99);
			if (pick < 20 && all_written(n))
				patch_system(n);
			else if (pick < 40)
				load_system(n, SYS_RANDOM);
			else
				load_system(n, SYS_DOMINANT);
		end
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single unknown: saturating quotient, most negative values, zero diagonal
		set_config(1, 66, 1000);
		send_word(0, 0, 32'h0000_0001, 0);
		send_word(0, 1, 32'h7FFF_FFFF, 1);
		send_word(0, 0, 32'h8000_0000, 0);
		send_word(0, 1, 32'h8000_0000, 1);
		send_word(0, 0, 32'h0000_0000, 1);
		// strays are dropped, even one carrying tlast
		send_word(15, 16, $urandom, 0);
		send_word(0, 31, $urandom, 0);
		send_word(0, 0, 32'h0001_0000, 0);
		send_word(0, 1, 32'hFFFB_0000, 0);
		send_word(9, 0, 32'hFFFF_FFFF, 1);
		drain();

		// dimension zero acts as one, sweep cap zero as one sweep
		set_config(0, 1, 0);
		send_word(15, 0, $urandom, 1);
		drain();

		// widest tolerance, highest cap
		set_config(3, 32'h7FFF_FFFF, 65535);
		load_system(3, SYS_DOMINANT);
		drain();
		send_word(1, 1, 32'h0, 1);
		drain();

		// tightest tolerance, small cap
		set_config(2, 1, 40);
		load_system(2, SYS_DOMINANT);

		// sink idles more than sender, then the reverse, then full rate with a long hold
		random_phase(34, 62, 0);
		random_phase(62, 34, 0);
		random_phase(0, 0, 1);

		// a wider system once
		drain();
		set_config(6, 66, 100);
		load_system(6, SYS_DOMINANT);
		drain();

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
